@@ sv/rgp_pkg.sv @@
package rgp_pkg;

  // Geometry limits
  localparam int unsigned MAX_SIDE = 4096;
  localparam int unsigned SIDE_W   = 13;
  localparam int unsigned POSX_W   = 13;
  localparam int unsigned POSY_W   = 12;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned NUM_CH   = 3;

  // Datapath widths
  localparam int unsigned DX_W   = 14;  // signed column offset
  localparam int unsigned DY_W   = 13;  // signed row offset
  localparam int unsigned DX2_W  = 26;
  localparam int unsigned DY2_W  = 24;
  localparam int unsigned R2_W   = 25;
  localparam int unsigned SUM_W  = 27;
  localparam int unsigned PROD_W = CHAN_W + R2_W;       // |inner-outer| * m
  localparam int unsigned DIV_STEPS = CHAN_W;            // quotient bits
  localparam int unsigned DSH_W  = R2_W + DIV_STEPS - 1; // r2 aligned to top quotient bit

  // Pipeline depth: 3 geometry, 1 multiply, divider steps, 1 output
  localparam int unsigned GEO_STAGES = 3;
  localparam int unsigned MUL_STAGE  = GEO_STAGES;
  localparam int unsigned DIV_FIRST  = MUL_STAGE + 1;
  localparam int unsigned OUT_STAGE  = DIV_FIRST + DIV_STEPS;
  localparam int unsigned NUM_STAGES = OUT_STAGE + 1;

  // APB register map
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_AREA_WIDTH  = 3'd0,
    REG_AREA_HEIGHT = 3'd1,
    REG_CENTERED    = 3'd2,
    REG_INNER_COLOR = 3'd3,
    REG_OUTER_COLOR = 3'd4
  } rgp_reg_e;

  typedef struct packed {
    logic [SIDE_W-1:0]  area_width;
    logic [SIDE_W-1:0]  area_height;
    logic               centered;
    logic [COLOR_W-1:0] inner_color;
    logic [COLOR_W-1:0] outer_color;
  } rgp_cfg_t;

  // Result of the geometry stages
  typedef struct packed {
    logic            in_circle;
    logic [R2_W-1:0] m;
    logic [R2_W-1:0] r2;
  } rgp_geo_t;

  // Payload carried through the divider stages
  typedef struct packed {
    logic                           in_circle;
    logic [NUM_CH-1:0]              neg;
    logic [NUM_CH-1:0][PROD_W-1:0]  rem;
    logic [NUM_CH-1:0][CHAN_W-1:0]  quo;
    logic [DSH_W-1:0]               dsh;
  } rgp_div_t;

endpackage

@@ sv/radial_gradient_pixel_generator_unit.sv @@
// Radial gradient pixel generator. Each accepted item is a pixel coordinate
// (pos_x_i, pos_y_i); each result is its RGB color plus an outside flag for
// pixels at or beyond the radius. The datapath is a 13-stage pipeline: three
// geometry stages (offsets, squares, margin), one multiply stage, eight
// restoring divider stages that each resolve one quotient bit for all three
// channels, and the output register. It takes one item per clock while
// in_ready_o is high.
// Stalls collapse bubbles, so in_ready_o drops only once all 13 stages hold
// an item and out_ready_i is low. Program the registers over APB (word
// addresses 0..4: width, height, centered, inner color, outer color) only
// while no items are in flight.
module radial_gradient_pixel_generator_unit
  import rgp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [POSX_W-1:0] pos_x_i,
  input  logic [POSY_W-1:0] pos_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAN_W-1:0] red_o,
  output logic [CHAN_W-1:0] green_o,
  output logic [CHAN_W-1:0] blue_o,
  output logic              outside_o
);

  rgp_cfg_t cfg;
  rgp_geo_t geo;
  rgp_div_t div_pipe [DIV_STEPS+1];

  // Pipeline control: a stage loads when empty or when it drains onward
  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES:0]   rdy;

  always_comb begin
    rdy[NUM_STAGES] = out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k-1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[OUT_STAGE];

  // Configuration registers
  rgp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Geometry stages
  rgp_geom u_geom (
    .clk_i   (clk_i),
    .load_i  (rdy[GEO_STAGES-1:0]),
    .cfg_i   (cfg),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .geo_o   (geo)
  );

  // Channel products
  rgp_mul u_mul (
    .clk_i  (clk_i),
    .load_i (rdy[MUL_STAGE]),
    .cfg_i  (cfg),
    .geo_i  (geo),
    .div_o  (div_pipe[0])
  );

  // Divider, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    rgp_div_step u_step (
      .clk_i  (clk_i),
      .load_i (rdy[DIV_FIRST+j]),
      .div_i  (div_pipe[j]),
      .div_o  (div_pipe[j+1])
    );
  end

  // Output stage: outer color plus signed quotient
  rgp_div_t                       fin;
  logic [NUM_CH-1:0][CHAN_W-1:0]  color_d, color_q;
  logic                           outside_d, outside_q;

  assign fin = div_pipe[DIV_STEPS];

  always_comb begin
    logic [CHAN_W-1:0] outer_c;
    outside_d = !fin.in_circle;
    for (int c = 0; c < NUM_CH; c++) begin
      outer_c = cfg.outer_color[c*CHAN_W +: CHAN_W];
      if (!fin.in_circle) begin
        color_d[c] = outer_c;
      end else if (fin.neg[c]) begin
        color_d[c] = outer_c - fin.quo[c];
      end else begin
        color_d[c] = outer_c + fin.quo[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[OUT_STAGE]) begin
      color_q   <= color_d;
      outside_q <= outside_d;
    end
  end

  assign red_o     = color_q[0];
  assign green_o   = color_q[1];
  assign blue_o    = color_q[2];
  assign outside_o = outside_q;

`ifndef SYNTH
  // Input stalls only when every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled with a free pipeline stage");

  // A held item in the first stage is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[0] && !rdy[1]) |=> valid_q[0])
    else $error("item lost in first stage");

  // Pixels outside the radius carry the outer color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outside_o) |->
      ((red_o == cfg.outer_color[7:0]) && (green_o == cfg.outer_color[15:8])
       && (blue_o == cfg.outer_color[23:16])))
    else $error("outside pixel not at outer color");
`endif

endmodule

@@ sv/rgp_cfg.sv @@
module rgp_cfg
  import rgp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output rgp_cfg_t          cfg_o
);

  rgp_cfg_t cfg_q, cfg_d;
  rgp_reg_e idx;
  logic     wr_en;

  assign idx    = rgp_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_AREA_WIDTH:  cfg_d.area_width  = pwdata[SIDE_W-1:0];
        REG_AREA_HEIGHT: cfg_d.area_height = pwdata[SIDE_W-1:0];
        REG_CENTERED:    cfg_d.centered    = pwdata[0];
        REG_INNER_COLOR: cfg_d.inner_color = pwdata[COLOR_W-1:0];
        REG_OUTER_COLOR: cfg_d.outer_color = pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Readback
  always_comb begin
    prdata = '0;
    case (idx)
      REG_AREA_WIDTH:  prdata = DATA_W'(cfg_q.area_width);
      REG_AREA_HEIGHT: prdata = DATA_W'(cfg_q.area_height);
      REG_CENTERED:    prdata = DATA_W'(cfg_q.centered);
      REG_INNER_COLOR: prdata = DATA_W'(cfg_q.inner_color);
      REG_OUTER_COLOR: prdata = DATA_W'(cfg_q.outer_color);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/rgp_geom.sv @@
module rgp_geom
  import rgp_pkg::*;
(
  input  logic                  clk_i,
  input  logic [GEO_STAGES-1:0] load_i,
  input  rgp_cfg_t              cfg_i,
  input  logic [POSX_W-1:0]     pos_x_i,
  input  logic [POSY_W-1:0]     pos_y_i,
  output rgp_geo_t              geo_o
);

  // Stage 1: clamp sides, radius, center offsets
  logic [SIDE_W-1:0]      wc, hc, rad_min, rad_d, rad_q;
  logic [SIDE_W-2:0]      cx, cy;
  logic signed [DX_W-1:0] dx_d, dx_q;
  logic signed [DY_W-1:0] dy_d, dy_q;

  always_comb begin
    wc = (cfg_i.area_width  > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg_i.area_width;
    hc = (cfg_i.area_height > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg_i.area_height;
    rad_min = (wc < hc) ? wc : hc;
    if (cfg_i.centered) begin
      rad_d = rad_min >> 1;
      cx    = wc[SIDE_W-1:1];
      cy    = hc[SIDE_W-1:1];
    end else begin
      rad_d = rad_min;
      cx    = '0;
      cy    = '0;
    end
    dx_d = signed'({1'b0, pos_x_i}) - signed'({2'b00, cx});
    dy_d = signed'({1'b0, pos_y_i}) - signed'({1'b0, cy});
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      rad_q <= rad_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
    end
  end

  // Stage 2: squares
  logic signed [2*DX_W-1:0] dx_sq;
  logic signed [2*DY_W-1:0] dy_sq;
  logic [2*SIDE_W-1:0]      r_sq;
  logic [DX2_W-1:0]         dx2_q;
  logic [DY2_W-1:0]         dy2_q;
  logic [R2_W-1:0]          r2_q;

  always_comb begin
    dx_sq = dx_q * dx_q;
    dy_sq = dy_q * dy_q;
    r_sq  = rad_q * rad_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      dx2_q <= dx_sq[DX2_W-1:0];
      dy2_q <= dy_sq[DY2_W-1:0];
      r2_q  <= r_sq[R2_W-1:0];
    end
  end

  // Stage 3: margin m = r2 - distance squared, positive means within the radius
  logic [SUM_W-1:0] dist2;
  rgp_geo_t         geo_d, geo_q;

  always_comb begin
    dist2           = SUM_W'(dx2_q) + SUM_W'(dy2_q);
    geo_d.in_circle = SUM_W'(r2_q) > dist2;
    geo_d.m         = r2_q - dist2[R2_W-1:0];
    geo_d.r2        = r2_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      geo_q <= geo_d;
    end
  end

  assign geo_o = geo_q;

endmodule

@@ sv/rgp_mul.sv @@
module rgp_mul
  import rgp_pkg::*;
(
  input  logic     clk_i,
  input  logic     load_i,
  input  rgp_cfg_t cfg_i,
  input  rgp_geo_t geo_i,
  output rgp_div_t div_o
);

  rgp_div_t div_d, div_q;

  // Per channel |inner - outer| * m, sign kept for the final add
  always_comb begin
    logic signed [CHAN_W:0] diff;
    logic [CHAN_W-1:0]      mag;
    div_d.in_circle = geo_i.in_circle;
    div_d.dsh       = {geo_i.r2, {(DIV_STEPS-1){1'b0}}};
    for (int c = 0; c < NUM_CH; c++) begin
      diff = signed'({1'b0, cfg_i.inner_color[c*CHAN_W +: CHAN_W]})
           - signed'({1'b0, cfg_i.outer_color[c*CHAN_W +: CHAN_W]});
      mag  = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
      div_d.neg[c] = diff[CHAN_W];
      div_d.rem[c] = mag * geo_i.m;
      div_d.quo[c] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

@@ sv/rgp_div_step.sv @@
module rgp_div_step
  import rgp_pkg::*;
(
  input  logic     clk_i,
  input  logic     load_i,
  input  rgp_div_t div_i,
  output rgp_div_t div_o
);

  rgp_div_t div_d, div_q;

  // One restoring step: subtract aligned divisor where it fits, shift divisor down
  always_comb begin
    logic ge;
    div_d        = div_i;
    div_d.dsh    = div_i.dsh >> 1;
    for (int c = 0; c < NUM_CH; c++) begin
      ge = div_i.rem[c] >= PROD_W'(div_i.dsh);
      if (ge) begin
        div_d.rem[c] = div_i.rem[c] - PROD_W'(div_i.dsh);
      end
      div_d.quo[c] = {div_i.quo[c][CHAN_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

@@ sim/radial_gradient_pixel_generator_unit_tb.sv @@
module radial_gradient_pixel_generator_unit_tb
  import rgp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REG_STRIDE     = 4;
  localparam int unsigned UNUSED_REG_IDX = 7;     // decodes to no register
  localparam int unsigned STUCK_LIMIT    = 2000;  // cycles without any transfer
  localparam int unsigned PHASE_ITEMS    = 66;
  localparam int unsigned NUM_PHASES     = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              outside;
  } gradient_px_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [POSX_W-1:0] pos_x_i;
  logic [POSY_W-1:0] pos_y_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CHAN_W-1:0] red_o;
  logic [CHAN_W-1:0] green_o;
  logic [CHAN_W-1:0] blue_o;
  logic              outside_o;

  // Shadow of the register file as the block should see it
  rgp_cfg_t     gradient_cfg;
  gradient_px_t expected_pixels[$];
  int unsigned  error_count  = 0;
  int unsigned  stuck_cycles = 0;
  int unsigned  stall_left   = 0;
  bit           gap_en       = 1'b1;
  bit           stall_en     = 1'b1;

  radial_gradient_pixel_generator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .outside_o   (outside_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Effective geometry: saturated sides, radius and center
  function automatic void gradient_geometry(output longint w, output longint h,
                                            output longint rad, output longint cx,
                                            output longint cy);
    w = (gradient_cfg.area_width > MAX_SIDE) ? MAX_SIDE : gradient_cfg.area_width;
    h = (gradient_cfg.area_height > MAX_SIDE) ? MAX_SIDE : gradient_cfg.area_height;
    rad = (w < h) ? w : h;
    cx = 0;
    cy = 0;
    if (gradient_cfg.centered) begin
      rad = rad / 2;
      cx = w / 2;
      cy = h / 2;
    end
  endfunction

  // Color of one pixel under the current settings
  function automatic gradient_px_t shade_pixel(input logic [POSX_W-1:0] x,
                                               input logic [POSY_W-1:0] y);
    longint w, h, rad, cx, cy, dx, dy, r2, margin, inner_ch, outer_ch, blend;
    logic [CHAN_W-1:0] chan [NUM_CH];
    gradient_px_t px;
    gradient_geometry(w, h, rad, cx, cy);
    dx = longint'(x) - cx;
    dy = longint'(y) - cy;
    r2 = rad * rad;
    margin = r2 - (dx * dx + dy * dy);
    px.outside = (margin <= 0) || (r2 == 0);
    for (int c = 0; c < NUM_CH; c++) begin
      inner_ch = gradient_cfg.inner_color[c*CHAN_W +: CHAN_W];
      outer_ch = gradient_cfg.outer_color[c*CHAN_W +: CHAN_W];
      // integer division truncates toward zero, as the hardware must
      blend = px.outside ? outer_ch : outer_ch + ((inner_ch - outer_ch) * margin) / r2;
      chan[c] = blend[CHAN_W-1:0];
    end
    px.red   = chan[0];
    px.green = chan[1];
    px.blue  = chan[2];
    return px;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 1;
      2:       return MAX_SIDE;
      3:       return '1;  // saturates to MAX_SIDE
      4, 5, 6: return $urandom_range(2, 64);
      default: return $urandom_range(0, MAX_SIDE + 50);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'h00FF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Record expectations at input acceptance, compare at output acceptance
  always @(posedge clk_i) begin
    gradient_px_t exp_px;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_pixels.push_back(shade_pixel(pos_x_i, pos_y_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel result with no pending item");
        error_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        check_field("red", exp_px.red, red_o);
        check_field("green", exp_px.green, green_o);
        check_field("blue", exp_px.blue, blue_o);
        check_field("outside", exp_px.outside, outside_o);
      end
    end
  end

  // Output back-pressure
  always @(negedge clk_i) begin
    if (stall_left == 0 && stall_en && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    out_ready_i <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  // Watchdog on cycles with no transfer on any port
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // APB write: setup then access; shadow follows the register map
  task automatic write_reg(input int unsigned idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(idx * REG_STRIDE);
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_AREA_WIDTH:  gradient_cfg.area_width  = val[SIDE_W-1:0];
      REG_AREA_HEIGHT: gradient_cfg.area_height = val[SIDE_W-1:0];
      REG_CENTERED:    gradient_cfg.centered    = val[0];
      REG_INNER_COLOR: gradient_cfg.inner_color = val[COLOR_W-1:0];
      REG_OUTER_COLOR: gradient_cfg.outer_color = val[COLOR_W-1:0];
      default:         ;  // unmapped address, no effect
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic program_gradient(input logic [DATA_W-1:0] width,
                                  input logic [DATA_W-1:0] height,
                                  input logic [DATA_W-1:0] centered,
                                  input logic [DATA_W-1:0] inner,
                                  input logic [DATA_W-1:0] outer);
    write_reg(REG_AREA_WIDTH, width);
    write_reg(REG_AREA_HEIGHT, height);
    write_reg(REG_CENTERED, centered);
    write_reg(REG_INNER_COLOR, inner);
    write_reg(REG_OUTER_COLOR, outer);
  endtask

  // Send one coordinate; valid stays up across back-to-back items
  task automatic send_pixel(input logic [POSX_W-1:0] x, input logic [POSY_W-1:0] y);
    int unsigned gap;
    gap = gap_en ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    pos_x_i    = x;
    pos_y_i    = y;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and let the pipeline empty before touching registers
  task automatic settle_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 2) @(posedge clk_i);
  endtask

  // All-zero registers: zero radius, every pixel outer and outside
  task automatic test_reset_state();
    send_pixel('0, '0);
    send_pixel('1, '1);
    settle_pipeline();
  endtask

  // Center at origin, radius = min side = 60
  task automatic test_origin_mode();
    program_gradient(100, 60, 0, 32'h0010_00FF, 32'h00EF_FF00);
    send_pixel(0, 0);
    send_pixel(59, 0);
    send_pixel(60, 0);   // exactly on the radius
    send_pixel(42, 42);
    send_pixel(100, 59);
    settle_pipeline();
  endtask

  // Centered: radius 30 around (50, 30); also inner equal to outer
  task automatic test_centered_mode();
    write_reg(REG_CENTERED, 1);
    send_pixel(50, 30);
    send_pixel(79, 30);
    send_pixel(80, 30);
    send_pixel(50, 0);
    send_pixel(0, 0);
    settle_pipeline();
    write_reg(REG_OUTER_COLOR, 32'h0010_00FF);
    send_pixel(60, 35);
    settle_pipeline();
  endtask

  // Sides beyond the maximum saturate; largest radius and coordinates
  task automatic test_oversized_sides();
    program_gradient('1, 5000, 0, 32'h00FF_FFFF, 0);
    send_pixel(0, 0);
    send_pixel(4095, 0);
    send_pixel(4096, 0);
    send_pixel(0, 4095);
    send_pixel('1, '1);
    settle_pipeline();
  endtask

  task automatic test_ignored_register();
    write_reg(UNUSED_REG_IDX, '1);
    send_pixel(1, 1);
    send_pixel(4000, 100);
    settle_pipeline();
  endtask

  // Random settings; coordinates mostly in the area or near the circle
  task automatic test_random_gradients();
    longint w, h, rad, cx, cy, xv, yv, jitter;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       program_gradient(MAX_SIDE, MAX_SIDE, 0, 32'h00FF_FFFF, 0);
        1:       program_gradient(1, '1, 1, 0, 32'h00FF_FFFF);
        default: program_gradient(pick_side(), pick_side(), $urandom(), pick_color(),
                                  pick_color());
      endcase
      gap_en   = (phase != 3);
      stall_en = (phase != 3);
      gradient_geometry(w, h, rad, cx, cy);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        jitter = longint'($urandom_range(0, 4)) - 2;
        case ($urandom_range(0, 9))
          0, 1: begin
            xv = $urandom();
            yv = $urandom();
          end
          2, 3, 4: begin
            case ($urandom_range(0, 2))
              0: begin xv = cx + rad + jitter; yv = cy; end
              1: begin xv = cx; yv = cy - rad + jitter; end
              default: begin
                xv = cx + (rad * 7) / 10 + jitter;
                yv = cy + (rad * 7) / 10;
              end
            endcase
          end
          default: begin
            xv = $urandom_range(0, int'(w));
            yv = (h == 0) ? 0 : $urandom_range(0, int'(h) - 1);
          end
        endcase
        send_pixel(xv[POSX_W-1:0], yv[POSY_W-1:0]);
      end
      settle_pipeline();
    end
    gap_en   = 1'b1;
    stall_en = 1'b1;
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    pos_x_i      = '0;
    pos_y_i      = '0;
    gradient_cfg = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_origin_mode();
    test_centered_mode();
    test_oversized_sides();
    test_ignored_register();
    test_random_gradients();

    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
